@@ hw/rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find-and-replace block
// Holds the register indexes, the control structs of the pending window and
// the sequencer phase codes.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int BYTE_W      = 8;
    localparam int PLEN_W      = 4;
    localparam int RLEN_W      = 6;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_WORD_0 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd6;

    // Controls for the whole window.
    typedef struct packed {
        logic shift;   // the oldest byte leaves, every cell takes its neighbor
        logic append;  // the incoming byte is written behind the pending bytes
    } win_ctrl_t;

    // Controls for one cell.
    typedef struct packed {
        logic shift;
        logic write;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        PH_HEAD  = 3'b001,
        PH_REPL  = 3'b010,
        PH_FLUSH = 3'b100
    } phase_t;

endpackage

@@ hw/rtl/sfr_cell.sv @@
// ----------------------------------------------------------------------------
// sfr_cell: one byte of the pending window
// Holds a pending byte, takes the byte of its neighbor on a shift or the new
// text byte on a write, and compares both against its pattern byte.
// ----------------------------------------------------------------------------
module sfr_cell
    import sfr_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [BYTE_W-1:0] neighbor_byte,
    input  logic [BYTE_W-1:0] new_byte,
    input  logic [BYTE_W-1:0] pattern_byte,
    output logic [BYTE_W-1:0] held_byte,
    output logic              eq_held,
    output logic              eq_new
);

    logic [BYTE_W-1:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.write)
        begin
            byte_reg <= new_byte;
        end
        else if (ctrl.shift)
        begin
            byte_reg <= neighbor_byte;
        end
    end

    assign held_byte = byte_reg;
    assign eq_held   = (byte_reg == pattern_byte);
    assign eq_new    = (new_byte == pattern_byte);

endmodule

@@ hw/rtl/sfr_window.sv @@
// ----------------------------------------------------------------------------
// sfr_window: chain of cells holding the pending bytes, oldest in cell zero
// Shifts toward cell zero, writes the new byte behind the pending ones and
// combines the per-cell compares into one match flag.
// ----------------------------------------------------------------------------
module sfr_window
    import sfr_pkg::*;
#(
    parameter int PATTERN_MAX = 8,
    parameter int CW          = 4
)
(
    input  logic                               clk,
    input  win_ctrl_t                          ctrl,
    input  logic [CW-1:0]                      count,
    input  logic [CW-1:0]                      len_eff,
    input  logic [BYTE_W-1:0]                  new_byte,
    input  logic [PATTERN_MAX-1:0][BYTE_W-1:0] pattern,
    output logic [BYTE_W-1:0]                  oldest,
    output logic                               match
);

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] held;
    logic [PATTERN_MAX-1:0]             eq_held;
    logic [PATTERN_MAX-1:0]             eq_new;
    logic [PATTERN_MAX-1:0]             pos_ok;
    logic [CW-1:0]                      target;

    // With a shift in the same cycle the new byte lands one place lower.
    assign target = ctrl.shift ? (count - CW'(1)) : count;

    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_cell
        cell_ctrl_t        cc;
        logic [BYTE_W-1:0] nb;

        assign cc.shift = ctrl.shift;
        assign cc.write = ctrl.append && (target == CW'(i));

        if (i == PATTERN_MAX - 1)
        begin : g_end
            assign nb = '0;
        end
        else
        begin : g_mid
            assign nb = held[i+1];
        end

        sfr_cell u_cell (
            .clk           (clk),
            .ctrl          (cc),
            .neighbor_byte (nb),
            .new_byte      (new_byte),
            .pattern_byte  (pattern[i]),
            .held_byte     (held[i]),
            .eq_held       (eq_held[i]),
            .eq_new        (eq_new[i])
        );

        // The new byte sits at position count once appended.
        always_comb
        begin
            if (CW'(i) >= len_eff)
            begin
                pos_ok[i] = 1'b1;
            end
            else if (CW'(i) < count)
            begin
                pos_ok[i] = eq_held[i];
            end
            else if (CW'(i) == count)
            begin
                pos_ok[i] = eq_new[i];
            end
            else
            begin
                pos_ok[i] = 1'b1;
            end
        end
    end

    assign oldest = held[0];
    assign match  = &pos_ok;

endmodule

@@ hw/rtl/stream_find_and_replace.sv @@
// ----------------------------------------------------------------------------
// stream_find_and_replace: replaces every leftmost non-overlapping occurrence
// of a configured pattern in a byte stream with a configured replacement.
// ----------------------------------------------------------------------------
// Channel  | Direction | Payload
// s_axis   | in        | tdata[7:0] text byte, tlast end of text
// m_axis   | out       | tdata[7:0] output byte, tuser from replacement,
//          |           | tlast last output caused by its input
// cfg      | in        | cfg_index register index, cfg_data value
//
// A text byte that stays pending, emits one byte or matches with an empty
// replacement is finished at once, so such bytes stream at one per cycle
// while the output register is not stalled. Otherwise a text byte is held
// until every output byte it causes is emitted: the replacement on a match,
// plus the pending bytes on a flush at end of text or after the pattern was
// shortened. An end-of-text byte that is only appended is flushed afterwards.
// The output register stalls the sequencer; the input takes the next
// transaction in the cycle the current one finishes.
// Reset clears the window count and sets the registers to their defaults.
// ----------------------------------------------------------------------------
module stream_find_and_replace
    import sfr_pkg::*;
#(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] in_byte
    input  logic                   s_axis_tlast,   // end_of_text

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [7:0] out_byte
    output logic                   m_axis_tuser,   // from_replacement
    output logic                   m_axis_tlast,   // run_last

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = $clog2(PATTERN_MAX + 1);
    localparam int RW = $clog2(REPLACE_MAX + 1);
    localparam int KW = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

    // Configuration registers.
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] pattern_reg;
    logic [PLEN_W-1:0]                  plen_reg;
    logic [BYTE_W-1:0]                  repl_reg [REPLACE_MAX];
    logic [RLEN_W-1:0]                  rlen_reg;
    logic                               cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            plen_reg    <= PLEN_W'(1);
            rlen_reg    <= '0;
            for (int b = 0; b < REPLACE_MAX; b++)
            begin
                repl_reg[b] <= '0;
            end
        end
        else if (cfg_fire)
        begin
            if (cfg_index == REG_PATTERN_BYTES)
            begin
                for (int i = 0; i < PATTERN_MAX; i++)
                begin
                    pattern_reg[i] <= cfg_data[8*i +: 8];
                end
            end
            if (cfg_index == REG_PATTERN_LENGTH)
            begin
                plen_reg <= cfg_data[PLEN_W-1:0];
            end
            if (cfg_index == REG_REPLACEMENT_LENGTH)
            begin
                rlen_reg <= cfg_data[RLEN_W-1:0];
            end
            for (int b = 0; b < REPLACE_MAX; b++)
            begin
                if (cfg_index == (REG_REPLACEMENT_WORD_0 + CFG_INDEX_W'(b / 8)))
                begin
                    repl_reg[b] <= cfg_data[8*(b % 8) +: 8];
                end
            end
        end
    end

    logic [CW-1:0] len_eff;
    logic [RW-1:0] rlen_eff;

    assign len_eff  = (plen_reg > PLEN_W'(PATTERN_MAX)) ? CW'(PATTERN_MAX) : CW'(plen_reg);
    assign rlen_eff = (rlen_reg > RLEN_W'(REPLACE_MAX)) ? RW'(REPLACE_MAX) : RW'(rlen_reg);

    // Item register, sequencer state and output register.
    logic              item_valid_reg;
    logic [BYTE_W-1:0] item_byte_reg;
    logic              item_end_reg;
    phase_t            phase_reg, phase_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              drained_reg, drained_next;
    logic [KW-1:0]     rep_idx_reg, rep_idx_next;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_rep_reg;
    logic              out_last_reg;

    win_ctrl_t         wctrl;
    logic [BYTE_W-1:0] oldest;
    logic              win_match;

    logic              emit;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_rep;
    logic              emit_last;
    logic              done;
    logic              adv;
    logic              go;
    logic              s_fire;
    logic [KW-1:0]     rep_sel;
    logic [BYTE_W-1:0] rep_byte;
    logic [CW-1:0]     cnt_inc;

    assign adv      = !out_valid_reg || m_axis_tready;
    assign rep_sel  = (phase_reg == PH_REPL) ? rep_idx_reg : '0;
    assign rep_byte = repl_reg[rep_sel];
    assign cnt_inc  = count_reg + CW'(1);

    always_comb
    begin
        emit         = 1'b0;
        emit_byte    = oldest;
        emit_rep     = 1'b0;
        emit_last    = 1'b0;
        done         = 1'b0;
        wctrl        = '0;
        count_next   = count_reg;
        phase_next   = phase_reg;
        drained_next = drained_reg;
        rep_idx_next = rep_idx_reg;

        if (item_valid_reg)
        begin
            case (phase_reg)
                PH_HEAD:
                begin
                    if (len_eff == '0)
                    begin
                        // Nothing can match: flush, then pass the byte through.
                        emit = 1'b1;
                        if (count_reg != '0)
                        begin
                            wctrl.shift = 1'b1;
                            count_next  = count_reg - CW'(1);
                        end
                        else
                        begin
                            emit_byte = item_byte_reg;
                            emit_last = 1'b1;
                            done      = 1'b1;
                        end
                    end
                    else if (count_reg >= len_eff)
                    begin
                        // The pattern was shortened while bytes were pending.
                        emit         = 1'b1;
                        wctrl.shift  = 1'b1;
                        count_next   = count_reg - CW'(1);
                        drained_next = 1'b1;
                    end
                    else if (cnt_inc == len_eff)
                    begin
                        if (!drained_reg && win_match)
                        begin
                            count_next = '0;
                            if (rlen_eff != '0)
                            begin
                                emit      = 1'b1;
                                emit_byte = rep_byte;
                                emit_rep  = 1'b1;
                                emit_last = (rlen_eff == RW'(1));
                                if (rlen_eff == RW'(1))
                                begin
                                    done = 1'b1;
                                end
                                else
                                begin
                                    phase_next   = PH_REPL;
                                    rep_idx_next = KW'(1);
                                end
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                        else
                        begin
                            emit = 1'b1;
                            if (count_reg == '0)
                            begin
                                emit_byte = item_byte_reg;
                            end
                            else
                            begin
                                wctrl.shift  = 1'b1;
                                wctrl.append = 1'b1;
                            end
                            emit_last = !(item_end_reg && count_reg != '0);
                            if (item_end_reg && count_reg != '0)
                            begin
                                phase_next = PH_FLUSH;
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        wctrl.append = 1'b1;
                        count_next   = cnt_inc;
                        if (item_end_reg)
                        begin
                            phase_next = PH_FLUSH;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                end

                PH_REPL:
                begin
                    emit      = 1'b1;
                    emit_byte = rep_byte;
                    emit_rep  = 1'b1;
                    emit_last = ((RW'(rep_idx_reg) + RW'(1)) == rlen_eff);
                    done      = emit_last;
                    rep_idx_next = rep_idx_reg + KW'(1);
                end

                PH_FLUSH:
                begin
                    emit        = 1'b1;
                    wctrl.shift = 1'b1;
                    count_next  = count_reg - CW'(1);
                    emit_last   = (count_reg == CW'(1));
                    done        = emit_last;
                end

                default:
                begin
                    phase_next = PH_HEAD;
                end
            endcase
        end

        if (done)
        begin
            phase_next   = PH_HEAD;
            drained_next = 1'b0;
        end
    end

    // Nothing moves while a byte is due and the output register is full.
    assign go            = !emit || adv;
    assign s_axis_tready = !item_valid_reg || (done && go);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    win_ctrl_t wctrl_go;
    assign wctrl_go.shift  = wctrl.shift && go;
    assign wctrl_go.append = wctrl.append && go;

    sfr_window #(
        .PATTERN_MAX (PATTERN_MAX),
        .CW          (CW)
    ) u_window (
        .clk      (clk),
        .ctrl     (wctrl_go),
        .count    (count_reg),
        .len_eff  (len_eff),
        .new_byte (item_byte_reg),
        .pattern  (pattern_reg),
        .oldest   (oldest),
        .match    (win_match)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_HEAD;
            count_reg      <= '0;
            drained_reg    <= 1'b0;
            rep_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (done && go)
            begin
                item_valid_reg <= 1'b0;
            end

            if (go)
            begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                drained_reg <= drained_next;
                rep_idx_reg <= rep_idx_next;
            end

            if (emit && adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_byte_reg <= s_axis_tdata;
            item_end_reg  <= s_axis_tlast;
        end
        if (emit && adv)
        begin
            out_byte_reg <= emit_byte;
            out_rep_reg  <= emit_rep;
            out_last_reg <= emit_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_rep_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ tb/sv/tb_stream_find_and_replace.sv @@
// ----------------------------------------------------------------------------
// tb_stream_find_and_replace: self-checking bench for the find-and-replace block
// A queue-fed driver sends text bytes on the input stream while a monitor
// checks every output transaction against a byte-level rewrite model kept in
// the bench. Directed text covers the corner cases; random phases then run
// with random patterns, replacements and stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb_stream_find_and_replace;
    import sfr_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 70;

    typedef struct {
        logic [7:0] text;
        logic       eot;
    } text_item_t;

    typedef struct {
        logic [7:0] data;
        logic       from_repl;
        logic       last;
    } out_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'h00;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [7:0]             m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Model copy of the registers and of the pending window.
    logic [63:0]  pat_reg = '0;
    logic [3:0]   plen_reg = 4'd1;
    logic [255:0] repl_reg = '0;
    logic [5:0]   rlen_reg = '0;
    logic [7:0]   pending_win [8];
    int unsigned  pending_cnt = 0;

    text_item_t text_queue [$];
    out_item_t  step_results [$];
    out_item_t  predicted_text [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned texts_taken = 0;
    int unsigned texts_seen = 0;
    int unsigned holds_requested = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;
    int unsigned results_out = 0;
    int unsigned repl_out = 0;
    int unsigned cfg_writes = 0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;

    stream_find_and_replace u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void add_result(input logic [7:0] data, input logic from_repl);
        out_item_t r;
        r.data = data;
        r.from_repl = from_repl;
        r.last = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void emit_oldest_pending();
        if (pending_cnt == 0)
            return;
        add_result(pending_win[0], 1'b0);
        for (int i = 1; i < 8; i++)
            pending_win[i-1] = pending_win[i];
        pending_win[7] = 8'h00;
        pending_cnt--;
    endfunction

    function automatic int unsigned eff_pattern_len();
        return (plen_reg > 4'd8) ? 8 : int'(plen_reg);
    endfunction

    // Works out the output transactions caused by one accepted text byte.
    function automatic void rewrite_byte(input logic [7:0] b, input logic eot);
        int unsigned len;
        int unsigned rlen;
        bit          drained;
        bit          hit;
        len = eff_pattern_len();
        rlen = (rlen_reg > 6'd32) ? 32 : int'(rlen_reg);
        drained = 1'b0;
        if (len == 0) begin
            while (pending_cnt > 0)
                emit_oldest_pending();
            add_result(b, 1'b0);
        end
        else begin
            // A pattern shortened while bytes pend drains the surplus first.
            while (pending_cnt >= len) begin
                emit_oldest_pending();
                drained = 1'b1;
            end
            pending_win[pending_cnt & 7] = b;
            pending_cnt++;
            if (pending_cnt == len) begin
                hit = !drained;
                for (int i = 0; i < len; i++)
                    if (pending_win[i] != pat_reg[8*i +: 8])
                        hit = 1'b0;
                if (hit) begin
                    for (int k = 0; k < rlen; k++)
                        add_result(repl_reg[8*k +: 8], 1'b1);
                    for (int i = 0; i < 8; i++)
                        pending_win[i] = 8'h00;
                    pending_cnt = 0;
                end
                else begin
                    emit_oldest_pending();
                end
            end
        end
        if (eot) begin
            while (pending_cnt > 0)
                emit_oldest_pending();
            for (int i = 0; i < 8; i++)
                pending_win[i] = 8'h00;
        end
        if (step_results.size() > 0)
            step_results[step_results.size()-1].last = 1'b1;
        foreach (step_results[i])
            predicted_text.push_back(step_results[i]);
        step_results.delete();
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("result %0d: %s got 0x%0h, expected 0x%0h", results_out, what, got, want);
        errors++;
    endtask

    // Input side: a new byte is offered once the previous one was taken.
    always @(negedge clk)
    begin : text_driver
        text_item_t item;
        if (!s_axis_tvalid || texts_taken != texts_seen) begin
            if (text_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                item = text_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= item.text;
                s_axis_tlast <= item.eot;
            end
            else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        texts_seen = texts_taken;
    end

    // Output side: random stalls, plus a long hold-off when one is requested.
    always @(negedge clk)
    begin : out_receiver
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else if (holds_requested != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                cfg_writes++;
                case (cfg_index)
                    REG_PATTERN_BYTES:      pat_reg = cfg_data;
                    REG_PATTERN_LENGTH:     plen_reg = cfg_data[3:0];
                    REG_REPLACEMENT_LENGTH: rlen_reg = cfg_data[5:0];
                    default:
                        if (cfg_index >= REG_REPLACEMENT_WORD_0
                                && cfg_index < REG_REPLACEMENT_LENGTH)
                            repl_reg[64*(cfg_index - REG_REPLACEMENT_WORD_0) +: 64] = cfg_data;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                texts_taken++;
                rewrite_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_text.size() == 0) begin
                    report_mismatch("unexpected transaction, out_byte", m_axis_tdata, 8'h00);
                end
                else begin
                    want = predicted_text.pop_front();
                    if (m_axis_tdata !== want.data)
                        report_mismatch("out_byte", m_axis_tdata, want.data);
                    if (m_axis_tuser !== want.from_repl)
                        report_mismatch("from_replacement", 8'(m_axis_tuser),
                                        8'(want.from_repl));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("run_last", 8'(m_axis_tlast), 8'(want.last));
                end
                if (m_axis_tuser === 1'b1)
                    repl_out++;
                results_out++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, predicted_text.size());
            $display("tb_stream_find_and_replace: FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input logic [63:0] pat, input logic [3:0] plen,
                                input logic [255:0] repl, input logic [5:0] rlen);
        write_reg(REG_PATTERN_BYTES, pat);
        write_reg(REG_PATTERN_LENGTH, {60'd0, plen});
        for (int i = 0; i < 4; i++)
            write_reg(REG_REPLACEMENT_WORD_0 + CFG_INDEX_W'(i), repl[64*i +: 64]);
        write_reg(REG_REPLACEMENT_LENGTH, {58'd0, rlen});
    endtask

    // Returns once the input is drained and every expected result has arrived,
    // plus a settling wait for a byte that is still in flight without a result.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (text_queue.size() != 0 || s_axis_tvalid || predicted_text.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void send(input logic [7:0] b, input logic eot);
        text_item_t item;
        item.text = b;
        item.eot = eot;
        text_queue.push_back(item);
    endfunction

    // Mostly the letters a and b, so patterns overlap and near-misses are common.
    function automatic logic [7:0] near_byte();
        return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h61 + 8'($urandom_range(1));
    endfunction

    function automatic logic [63:0] rand_pattern();
        logic [63:0] p;
        for (int i = 0; i < 8; i++)
            p[8*i +: 8] = near_byte();
        return p;
    endfunction

    function automatic logic [255:0] rand_repl();
        logic [255:0] r;
        for (int i = 0; i < 8; i++)
            r[32*i +: 32] = $urandom;
        return r;
    endfunction

    // Random text: whole pattern copies, broken prefixes and noise bytes.
    function automatic void fill_text(input int n);
        int unsigned len;
        int          made;
        int          r;
        int          cut;
        len = eff_pattern_len();
        made = 0;
        while (made < n) begin
            r = $urandom_range(99);
            if (len > 0 && r < 35)
                cut = len;
            else if (len > 1 && r < 50)
                cut = $urandom_range(len - 1, 1);
            else
                cut = 0;
            if (cut > 0) begin
                for (int k = 0; k < cut; k++)
                    send(pat_reg[8*k +: 8], $urandom_range(24) == 0);
                made += cut;
            end
            else begin
                send((r < 80) ? near_byte() : 8'($urandom_range(255)), $urandom_range(24) == 0);
                made++;
            end
        end
    endfunction

    initial
    begin
        for (int i = 0; i < 8; i++)
            pending_win[i] = 8'h00;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 59;

        // Reset settings: a zero byte matches and is deleted.
        send(8'h00, 1'b0);
        send(8'hFF, 1'b0);
        wait_idle();

        // Pattern "aba", full 32-byte replacement.
        program_regs(64'h0000_0000_0061_6261, 4'd3,
                     {64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF,
                      64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 6'd32);
        send(8'h61, 1'b0);
        send(8'h62, 1'b0);
        send(8'h61, 1'b0);
        // Leftmost non-overlapping match inside "abxababa", then a flush at end.
        send(8'h61, 1'b0);
        send(8'h62, 1'b0);
        send(8'h78, 1'b0);
        send(8'h61, 1'b0);
        send(8'h62, 1'b0);
        send(8'h61, 1'b0);
        send(8'h62, 1'b0);
        send(8'h61, 1'b0);
        send(8'h63, 1'b1);
        // Leave two bytes pending, then drop the pattern length to zero.
        send(8'h78, 1'b0);
        send(8'h79, 1'b0);
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        send(8'h7A, 1'b0);
        wait_idle();
        // Two bytes pend again, then the pattern is shortened below them.
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        send(8'h6D, 1'b0);
        send(8'h6E, 1'b0);
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, 64'd1);
        write_reg(REG_REPLACEMENT_LENGTH, 64'd0);
        send(8'h61, 1'b0);
        send(8'h61, 1'b0);
        wait_idle();

        // Oversized lengths act as the maximum sizes.
        program_regs(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, {8{32'hA5C3_0FF0}}, 6'd63);
        for (int i = 0; i < 8; i++)
            send(8'hFF, 1'b0);
        send(8'hFF, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 59 : 0;
            recv_idle_pct = (ph < 2) ? 59 : (ph < 4) ? 37 : 0;
            case (ph)
                0: program_regs(rand_pattern(), 4'd8, rand_repl(), 6'd32);
                1: program_regs(rand_pattern(), 4'd15, rand_repl(), 6'd63);
                2: program_regs(rand_pattern(), 4'd1, rand_repl(), 6'd0);
                3: program_regs(rand_pattern(), 4'd0, rand_repl(), 6'($urandom_range(32)));
                default: program_regs(rand_pattern(), 4'($urandom_range(7, 2)), rand_repl(),
                                      6'($urandom_range(40)));
            endcase
            if (ph == 0) begin
                // The receiver holds off while the sender keeps offering.
                fill_text(PHASE_ITEMS);
                holds_requested++;
            end
            else if (ph == 1) begin
                // The sender pauses until the output has fully drained.
                fill_text(PHASE_ITEMS / 2);
                wait_idle();
                fill_text(PHASE_ITEMS / 2);
            end
            else begin
                fill_text(PHASE_ITEMS);
            end
            wait_idle();
        end

        repeat (40) @(posedge clk);
        if (predicted_text.size() != 0)
            $display("%0d expected results never arrived", predicted_text.size());
        $display("covered %0d text bytes giving %0d output bytes, %0d from replacements",
                 texts_taken, results_out, repl_out);
        $display("with %0d register writes over directed cases and six random phases",
                 cfg_writes);
        if (errors == 0 && predicted_text.size() == 0)
            $display("tb_stream_find_and_replace: PASS");
        else
            $display("tb_stream_find_and_replace: FAIL");
        $finish;
    end

endmodule
